// File: design/ipp_pkg.sv
package ipp_pkg;

  typedef enum logic [2:0] {
    PH_UNDEC,
    PH_V4,
    PH_V6_TAIL,
    PH_V6_GROUP,
    PH_V6_LEAD
  } phase_e;

  localparam logic [4:0] GAP_NONE    = 5'd31;
  localparam logic [4:0] ADDR_BYTES  = 5'd16;
  localparam logic [9:0] DEC_SAT     = 10'd1023;
  localparam logic [9:0] OCTET_MAX   = 10'd255;
  localparam logic [7:0] BITS_SAT    = 8'd255;
  localparam logic [7:0] BITS_MAX_V4 = 8'd32;
  localparam logic [7:0] BITS_MAX_V6 = 8'd128;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // Byte 0 of the address is element 0.
  typedef logic [15:0][7:0] addr_t;

  typedef struct packed {
    addr_t       addr;
    logic [4:0]  byte_pos;
    logic [4:0]  gap_pos;
    phase_e      phase;
    logic [15:0] hex_acc;
    logic [9:0]  dec_acc;
    logic [2:0]  digit_count;
    logic        lead_zero;
    logic [1:0]  octet_index;
    logic        colon_seen;
    logic        in_bits;
    logic [2:0]  bits_count;
    logic        bits_lz;
    logic [7:0]  bits_acc;
    logic        failed;
  } scan_t;

  typedef struct packed {
    scan_t st;
    logic  mode_fail;
  } snap_t;

  typedef struct packed {
    logic        valid_res;
    logic        is_v4;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
  } res_t;

  localparam scan_t SCAN_INIT = '{
    addr:        '0,
    byte_pos:    '0,
    gap_pos:     GAP_NONE,
    phase:       PH_UNDEC,
    hex_acc:     '0,
    dec_acc:     '0,
    digit_count: '0,
    lead_zero:   1'b0,
    octet_index: '0,
    colon_seen:  1'b0,
    in_bits:     1'b0,
    bits_count:  '0,
    bits_lz:     1'b0,
    bits_acc:    '0,
    failed:      1'b0
  };

  function automatic logic is_dec(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    v = '0;
    if (is_dec(c)) begin
      v = {1'b1, c[3:0]};
    end else if (((c >= CH_LO_A) && (c <= CH_LO_F)) || ((c >= CH_UP_A) && (c <= CH_UP_F))) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic logic [2:0] sat_inc3(logic [2:0] n);
    return (n == 3'd7) ? n : n + 3'd1;
  endfunction

  function automatic logic [9:0] dec_step(logic [9:0] acc, logic [7:0] c);
    logic [13:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {10'b0, c[3:0]};
    return (v > {4'b0, DEC_SAT}) ? DEC_SAT : v[9:0];
  endfunction

  function automatic logic [7:0] bits_step(logic [7:0] acc, logic [7:0] c);
    logic [11:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {8'b0, c[3:0]};
    return (v > {4'b0, BITS_SAT}) ? BITS_SAT : v[7:0];
  endfunction

  function automatic logic octet_bad(scan_t s);
    return (s.digit_count == 3'd0) || (s.digit_count > 3'd3) || (s.dec_acc > OCTET_MAX) ||
           (s.lead_zero && (s.digit_count > 3'd1));
  endfunction

  function automatic scan_t take_digit(scan_t s, logic [7:0] c, logic [3:0] hv);
    scan_t r;
    r = s;
    if ((s.digit_count == 3'd0) && (c == CH_0)) r.lead_zero = 1'b1;
    r.digit_count = sat_inc3(s.digit_count);
    r.hex_acc     = {s.hex_acc[11:0], hv};
    r.dec_acc     = is_dec(c) ? dec_step(s.dec_acc, c) : DEC_SAT;
    if (r.digit_count > 3'd4) r.failed = 1'b1;
    return r;
  endfunction

  function automatic scan_t clear_digits(scan_t s);
    scan_t r;
    r = s;
    r.hex_acc     = '0;
    r.dec_acc     = '0;
    r.digit_count = '0;
    r.lead_zero   = 1'b0;
    return r;
  endfunction

  function automatic scan_t end_group(scan_t s);
    scan_t r;
    r = s;
    if ((s.digit_count == 3'd0) || (s.digit_count > 3'd4) || (s.byte_pos > 5'd14)) begin
      r.failed = 1'b1;
    end else begin
      r.addr[s.byte_pos[3:0]]        = s.hex_acc[15:8];
      r.addr[s.byte_pos[3:0] + 4'd1] = s.hex_acc[7:0];
      r.byte_pos                     = s.byte_pos + 5'd2;
    end
    return r;
  endfunction

endpackage

// File: design/ipp_char_if.sv
interface ipp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// File: design/ipp_res_if.sv
interface ipp_res_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic        is_v4;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [7:0]  prefix_len;

  modport source (
    output valid, output valid_res, output is_v4, output addr_hi, output addr_lo,
    output prefix_len, input ready
  );
  modport sink (
    input valid, input valid_res, input is_v4, input addr_hi, input addr_lo,
    input prefix_len, output ready
  );
endinterface

// File: design/ipp_scan.sv
module ipp_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               prefix_mode_i,
  ipp_char_if.sink           char_i,
  input  logic               take_ready_i,
  output logic               snap_valid_o,
  output ipp_pkg::snap_t     snap_o
);

  ipp_pkg::scan_t st_q, st_d;
  logic           fire;

  assign char_i.ready = take_ready_i;
  assign fire         = char_i.valid && char_i.ready;

  always_comb begin
    logic [7:0] c;
    logic [4:0] hv;
    logic [3:0] idx;
    c   = char_i.char_code;
    hv  = ipp_pkg::hex_val(c);
    idx = '0;
    st_d = st_q;
    if (!st_q.failed) begin
      if (st_q.in_bits) begin
        if (!ipp_pkg::is_dec(c)) begin
          st_d.failed = 1'b1;
        end else begin
          if ((st_q.bits_count == 3'd0) && (c == ipp_pkg::CH_0)) st_d.bits_lz = 1'b1;
          st_d.bits_count = ipp_pkg::sat_inc3(st_q.bits_count);
          st_d.bits_acc   = ipp_pkg::bits_step(st_q.bits_acc, c);
        end
      end else if ((c == ipp_pkg::CH_SLASH) && prefix_mode_i) begin
        // The address part is closed later, in the finish stage, from the frozen fields.
        st_d.in_bits = 1'b1;
      end else begin
        unique case (st_q.phase)
          ipp_pkg::PH_UNDEC: begin
            if (hv[4]) begin
              st_d = ipp_pkg::take_digit(st_q, c, hv[3:0]);
            end else if (c == ipp_pkg::CH_DOT) begin
              if (ipp_pkg::octet_bad(st_q)) st_d.failed = 1'b1;
              else st_d.addr[0] = st_q.dec_acc[7:0];
              st_d.phase       = ipp_pkg::PH_V4;
              st_d.octet_index = 2'd1;
              st_d             = ipp_pkg::clear_digits(st_d);
            end else if (c == ipp_pkg::CH_COLON) begin
              if (st_q.digit_count == 3'd0) begin
                st_d.phase = ipp_pkg::PH_V6_LEAD;
              end else begin
                st_d            = ipp_pkg::end_group(st_q);
                st_d.phase      = ipp_pkg::PH_V6_GROUP;
                st_d.colon_seen = 1'b1;
                st_d            = ipp_pkg::clear_digits(st_d);
              end
            end else begin
              st_d.failed = 1'b1;
            end
          end
          ipp_pkg::PH_V4, ipp_pkg::PH_V6_TAIL: begin
            if (ipp_pkg::is_dec(c)) begin
              st_d = ipp_pkg::take_digit(st_q, c, hv[3:0]);
            end else if ((c == ipp_pkg::CH_DOT) && (st_q.octet_index < 2'd3)) begin
              if (st_q.phase == ipp_pkg::PH_V4) idx = {2'b0, st_q.octet_index};
              else idx = st_q.byte_pos[3:0] + {2'b0, st_q.octet_index};
              if (ipp_pkg::octet_bad(st_q)) st_d.failed = 1'b1;
              else st_d.addr[idx] = st_q.dec_acc[7:0];
              st_d.octet_index = st_q.octet_index + 2'd1;
              st_d             = ipp_pkg::clear_digits(st_d);
            end else begin
              st_d.failed = 1'b1;
            end
          end
          ipp_pkg::PH_V6_LEAD: begin
            if (c == ipp_pkg::CH_COLON) begin
              st_d.gap_pos    = '0;
              st_d.phase      = ipp_pkg::PH_V6_GROUP;
              st_d.colon_seen = 1'b0;
            end else begin
              st_d.failed = 1'b1;
            end
          end
          ipp_pkg::PH_V6_GROUP: begin
            if (hv[4]) begin
              st_d            = ipp_pkg::take_digit(st_q, c, hv[3:0]);
              st_d.colon_seen = 1'b0;
            end else if (c == ipp_pkg::CH_COLON) begin
              if (st_q.digit_count != 3'd0) begin
                st_d = ipp_pkg::end_group(st_q);
                if (st_d.byte_pos >= ipp_pkg::ADDR_BYTES) st_d.failed = 1'b1;
                st_d.colon_seen = 1'b1;
                st_d            = ipp_pkg::clear_digits(st_d);
              end else if (st_q.colon_seen && (st_q.gap_pos == ipp_pkg::GAP_NONE)) begin
                st_d.gap_pos    = st_q.byte_pos;
                st_d.colon_seen = 1'b0;
              end else begin
                st_d.failed = 1'b1;
              end
            end else if (c == ipp_pkg::CH_DOT) begin
              if ((st_q.digit_count == 3'd0) || (st_q.byte_pos > 5'd12) ||
                  ((st_q.gap_pos == ipp_pkg::GAP_NONE) && (st_q.byte_pos != 5'd12))) begin
                st_d.failed = 1'b1;
              end else begin
                if (ipp_pkg::octet_bad(st_q)) st_d.failed = 1'b1;
                else st_d.addr[st_q.byte_pos[3:0]] = st_q.dec_acc[7:0];
                st_d.phase       = ipp_pkg::PH_V6_TAIL;
                st_d.octet_index = 2'd1;
                st_d             = ipp_pkg::clear_digits(st_d);
              end
            end else begin
              st_d.failed = 1'b1;
            end
          end
          default: begin
            st_d.failed = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ipp_pkg::SCAN_INIT;
    end else if (fire) begin
      st_q <= char_i.last_char ? ipp_pkg::SCAN_INIT : st_d;
    end
  end

  assign snap_valid_o     = fire && char_i.last_char;
  assign snap_o.st        = st_d;
  assign snap_o.mode_fail = !st_d.in_bits && prefix_mode_i;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && char_i.last_char |=> st_q == ipp_pkg::SCAN_INIT)
    else $error("parser state not cleared after the last character");

  a_byte_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.byte_pos <= ipp_pkg::ADDR_BYTES)
    else $error("byte position beyond the address");

  a_gap_behind_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.gap_pos == ipp_pkg::GAP_NONE) || (st_q.gap_pos <= st_q.byte_pos))
    else $error("gap position ahead of byte position");

endmodule

// File: design/ipp_finish.sv
module ipp_finish (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            snap_valid_i,
  input  ipp_pkg::snap_t  snap_i,
  output logic            take_ready_o,
  ipp_res_if.source       res_o
);

  logic           snap_valid_q;
  ipp_pkg::snap_t snap_q;
  logic           res_valid_q;
  ipp_pkg::res_t  res_q, res_d;
  logic           res_free;

  assign res_free     = !res_valid_q || res_o.ready;
  assign take_ready_o = !snap_valid_q || res_free;

  always_comb begin
    ipp_pkg::scan_t s;
    ipp_pkg::addr_t a;
    ipp_pkg::addr_t o;
    logic           f;
    logic           do_v6;
    logic [4:0]     nfill;
    logic [4:0]     jj;
    logic [7:0]     bmax;
    s     = snap_q.st;
    a     = s.addr;
    o     = '0;
    f     = s.failed || snap_q.mode_fail;
    do_v6 = 1'b0;
    nfill = '0;
    jj    = '0;

    // Close the address part.
    unique case (s.phase)
      ipp_pkg::PH_V4: begin
        if ((s.octet_index != 2'd3) || ipp_pkg::octet_bad(s)) f = 1'b1;
        else a[3] = s.dec_acc[7:0];
      end
      ipp_pkg::PH_V6_TAIL: begin
        if ((s.octet_index != 2'd3) || (s.byte_pos > 5'd12) || ipp_pkg::octet_bad(s)) begin
          f = 1'b1;
        end else begin
          a[s.byte_pos[3:0] + 4'd3] = s.dec_acc[7:0];
          s.byte_pos                = s.byte_pos + 5'd4;
          do_v6                     = 1'b1;
        end
      end
      ipp_pkg::PH_V6_GROUP: begin
        if (s.digit_count != 3'd0) begin
          s     = ipp_pkg::end_group(s);
          a     = s.addr;
          f     = f || s.failed;
          do_v6 = 1'b1;
        end else if (s.colon_seen) begin
          f = 1'b1;
        end else begin
          do_v6 = 1'b1;
        end
      end
      default: begin
        f = 1'b1;
      end
    endcase

    // Expand the "::" gap: the bytes behind it move to the end, zeros fill the hole.
    o = a;
    if (do_v6 && !f) begin
      if (s.byte_pos < ipp_pkg::ADDR_BYTES) begin
        if ((s.gap_pos == ipp_pkg::GAP_NONE) || (s.gap_pos > s.byte_pos)) begin
          f = 1'b1;
        end else begin
          nfill = ipp_pkg::ADDR_BYTES - s.byte_pos;
          for (int j = 0; j < 16; j++) begin
            jj = 5'(j);
            if (jj < s.gap_pos) o[j] = a[j];
            else if (jj < (s.gap_pos + nfill)) o[j] = '0;
            else o[j] = a[4'(jj - nfill)];
          end
        end
      end else if ((s.byte_pos > ipp_pkg::ADDR_BYTES) || (s.gap_pos != ipp_pkg::GAP_NONE)) begin
        f = 1'b1;
      end
    end

    bmax = (s.phase == ipp_pkg::PH_V4) ? ipp_pkg::BITS_MAX_V4 : ipp_pkg::BITS_MAX_V6;
    if (s.in_bits && ((s.bits_count == 3'd0) || (s.bits_count > 3'd3) ||
                      (s.bits_lz && (s.bits_count > 3'd1)) || (s.bits_acc > bmax))) begin
      f = 1'b1;
    end

    res_d = '0;
    if (!f) begin
      res_d.valid_res  = 1'b1;
      res_d.is_v4      = (s.phase == ipp_pkg::PH_V4);
      res_d.prefix_len = s.in_bits ? s.bits_acc : '0;
      for (int k = 0; k < 8; k++) begin
        res_d.addr_hi[8*(7-k) +: 8] = o[k];
        res_d.addr_lo[8*(7-k) +: 8] = o[k+8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (take_ready_o) snap_valid_q <= snap_valid_i;
      if (res_free) res_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_ready_o && snap_valid_i) snap_q <= snap_i;
    if (res_free && snap_valid_q) res_q <= res_d;
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.valid_res  = res_q.valid_res;
  assign res_o.is_v4      = res_q.is_v4;
  assign res_o.addr_hi    = res_q.addr_hi;
  assign res_o.addr_lo    = res_q.addr_lo;
  assign res_o.prefix_len = res_q.prefix_len;

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.valid_res |->
      !res_q.is_v4 && (res_q.addr_hi == '0) && (res_q.addr_lo == '0) &&
      (res_q.prefix_len == '0))
    else $error("rejected address carries nonzero fields");

  a_v4_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.is_v4 |->
      (res_q.addr_lo == '0) && (res_q.addr_hi[31:0] == '0) &&
      (res_q.prefix_len <= ipp_pkg::BITS_MAX_V4))
    else $error("IPv4 result outside the top 32 bits or prefix too long");

  a_snap_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q && !res_free |=> snap_valid_q && $stable(snap_q))
    else $error("waiting address lost while the result stage is blocked");

endmodule

// File: design/ip_address_text_parser.sv
// Parses the text of an IPv4 or IPv6 address, optionally with a "/bits" prefix suffix.
// char_i carries one request per character (char_code, last_char); the text ends
// with the request whose last_char is set. res_o delivers one result per text:
// valid_res, is_v4, the address as addr_hi/addr_lo (byte 0 in the top bits), and
// prefix_len. Malformed text yields a result with every field zero.
// cfg_we_i/cfg_wdata_i write the prefix-mode bit; write it only while no text is
// in flight.
// Each accepted character updates the scan registers, so char_i sustains one request
// per cycle while char_i.ready is high. The last character of a text is registered in
// the finish register and then moves on into the result register, which drives
// res_o.valid; the gap expansion and range checks sit in between.
// When res_o stalls, the finished result holds in the result register and one more
// finished text holds in the finish register; only then does char_i.ready drop.
// Reset clears the prefix-mode bit, the scan state and both output stages; no
// result is pending after reset.
module ip_address_text_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  ipp_char_if.sink   char_i,
  ipp_res_if.source  res_o
);

  logic           prefix_mode_q;
  logic           take_ready;
  logic           snap_valid;
  ipp_pkg::snap_t snap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      prefix_mode_q <= cfg_wdata_i;
    end
  end

  ipp_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .prefix_mode_i (prefix_mode_q),
    .char_i        (char_i),
    .take_ready_i  (take_ready),
    .snap_valid_o  (snap_valid),
    .snap_o        (snap)
  );

  ipp_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .take_ready_o (take_ready),
    .res_o        (res_o)
  );

endmodule

// File: tb/sv/ipp_result_checker.sv
`timescale 1ns / 1ps

module ipp_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  ipp_char_if  char_mon,
  ipp_res_if   res_mon,
  output int   fail_o,
  output int   pending_o
);

  // Shadow copy of the parser state.
  logic [7:0]       ab [16];
  logic [4:0]       bpos;
  logic [4:0]       gpos;
  ipp_pkg::phase_e  ph;
  logic             in_bits;
  logic             bits_v4;
  logic [15:0]      hacc;
  logic [9:0]       dacc;
  logic [2:0]       dcnt;
  logic             lz;
  logic [1:0]       oidx;
  logic             colon;
  logic [7:0]       bacc;
  logic             bad;
  logic             pmode;

  ipp_pkg::res_t parsed_addr_q [$];
  int            reported;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= ipp_pkg::CH_0) && (c <= ipp_pkg::CH_9);
  endfunction

  function automatic int hexv(logic [7:0] c);
    if (is_digit(c)) return int'(c) - int'(ipp_pkg::CH_0);
    if ((c >= ipp_pkg::CH_LO_A) && (c <= ipp_pkg::CH_LO_F)) begin
      return int'(c) - int'(ipp_pkg::CH_LO_A) + 10;
    end
    if ((c >= ipp_pkg::CH_UP_A) && (c <= ipp_pkg::CH_UP_F)) begin
      return int'(c) - int'(ipp_pkg::CH_UP_A) + 10;
    end
    return -1;
  endfunction

  task automatic clear_num();
    hacc = '0;
    dacc = '0;
    dcnt = '0;
    lz   = 1'b0;
  endtask

  task automatic clear_all();
    foreach (ab[i]) ab[i] = '0;
    bpos    = '0;
    gpos    = ipp_pkg::GAP_NONE;
    ph      = ipp_pkg::PH_UNDEC;
    in_bits = 1'b0;
    bits_v4 = 1'b0;
    clear_num();
    oidx    = '0;
    colon   = 1'b0;
    bacc    = '0;
    bad     = 1'b0;
  endtask

  task automatic add_digit(input logic [7:0] c, input int hv);
    int v;
    if ((dcnt == 3'd0) && (c == ipp_pkg::CH_0)) lz = 1'b1;
    if (dcnt != 3'd7) dcnt = dcnt + 3'd1;
    hacc = {hacc[11:0], hv[3:0]};
    if (is_digit(c)) begin
      v = int'(dacc) * 10 + int'(c) - int'(ipp_pkg::CH_0);
      dacc = (v > int'(ipp_pkg::DEC_SAT)) ? ipp_pkg::DEC_SAT : v[9:0];
    end else begin
      dacc = ipp_pkg::DEC_SAT;
    end
    if (dcnt > 3'd4) bad = 1'b1;
  endtask

  task automatic close_octet(input int base);
    if ((dcnt < 3'd1) || (dcnt > 3'd3) || (dacc > ipp_pkg::OCTET_MAX) ||
        (lz && (dcnt > 3'd1))) begin
      bad = 1'b1;
    end else begin
      ab[(base + int'(oidx)) & 15] = dacc[7:0];
    end
  endtask

  task automatic close_group();
    if ((dcnt < 3'd1) || (dcnt > 3'd4) || (bpos > 5'd14)) begin
      bad = 1'b1;
    end else begin
      ab[int'(bpos) & 15]       = hacc[15:8];
      ab[(int'(bpos) + 1) & 15] = hacc[7:0];
      bpos = bpos + 5'd2;
    end
  endtask

  // Moves the groups after the "::" to the end and zero-fills the hole.
  task automatic expand_gap();
    int k;
    int nfill;
    if (bad) return;
    if (bpos < 5'd16) begin
      if ((gpos == ipp_pkg::GAP_NONE) || (gpos > bpos)) begin
        bad = 1'b1;
        return;
      end
      nfill = 16 - int'(bpos);
      for (k = int'(bpos); k > int'(gpos); k--) ab[(k - 1 + nfill) & 15] = ab[(k - 1) & 15];
      for (k = 0; k < nfill; k++) ab[(int'(gpos) + k) & 15] = '0;
    end else if ((bpos > 5'd16) || (gpos != ipp_pkg::GAP_NONE)) begin
      bad = 1'b1;
    end
  endtask

  task automatic close_addr(output logic fam4);
    fam4 = 1'b0;
    case (ph)
      ipp_pkg::PH_V4: begin
        fam4 = 1'b1;
        if (oidx != 2'd3) bad = 1'b1;
        else close_octet(0);
      end
      ipp_pkg::PH_V6_TAIL: begin
        if ((oidx != 2'd3) || (bpos > 5'd12)) begin
          bad = 1'b1;
        end else begin
          close_octet(int'(bpos));
          bpos = bpos + 5'd4;
          expand_gap();
        end
      end
      ipp_pkg::PH_V6_GROUP: begin
        if (dcnt > 3'd0) begin
          close_group();
          expand_gap();
        end else if (colon) begin
          bad = 1'b1;
        end else begin
          expand_gap();
        end
      end
      default: bad = 1'b1;
    endcase
  endtask

  task automatic addr_byte(input logic [7:0] c);
    int hv;
    hv = hexv(c);
    case (ph)
      ipp_pkg::PH_UNDEC: begin
        if (hv >= 0) begin
          add_digit(c, hv);
        end else if (c == ipp_pkg::CH_DOT) begin
          ph   = ipp_pkg::PH_V4;
          oidx = 2'd0;
          close_octet(0);
          oidx = 2'd1;
          clear_num();
        end else if (c == ipp_pkg::CH_COLON) begin
          if (dcnt == 3'd0) begin
            ph = ipp_pkg::PH_V6_LEAD;
          end else begin
            ph = ipp_pkg::PH_V6_GROUP;
            close_group();
            colon = 1'b1;
            clear_num();
          end
        end else begin
          bad = 1'b1;
        end
      end
      ipp_pkg::PH_V4, ipp_pkg::PH_V6_TAIL: begin
        if (is_digit(c)) begin
          add_digit(c, hv);
        end else if ((c == ipp_pkg::CH_DOT) && (oidx < 2'd3)) begin
          close_octet((ph == ipp_pkg::PH_V4) ? 0 : int'(bpos));
          oidx = oidx + 2'd1;
          clear_num();
        end else begin
          bad = 1'b1;
        end
      end
      ipp_pkg::PH_V6_LEAD: begin
        if (c == ipp_pkg::CH_COLON) begin
          gpos  = '0;
          ph    = ipp_pkg::PH_V6_GROUP;
          colon = 1'b0;
        end else begin
          bad = 1'b1;
        end
      end
      ipp_pkg::PH_V6_GROUP: begin
        if (hv >= 0) begin
          add_digit(c, hv);
          colon = 1'b0;
        end else if (c == ipp_pkg::CH_COLON) begin
          if (dcnt > 3'd0) begin
            close_group();
            if (bpos >= 5'd16) bad = 1'b1;
            colon = 1'b1;
            clear_num();
          end else if (colon && (gpos == ipp_pkg::GAP_NONE)) begin
            gpos  = bpos;
            colon = 1'b0;
          end else begin
            bad = 1'b1;
          end
        end else if (c == ipp_pkg::CH_DOT) begin
          if ((dcnt == 3'd0) || (bpos > 5'd12) ||
              ((gpos == ipp_pkg::GAP_NONE) && (bpos != 5'd12))) begin
            bad = 1'b1;
          end else begin
            ph   = ipp_pkg::PH_V6_TAIL;
            oidx = 2'd0;
            close_octet(int'(bpos));
            oidx = 2'd1;
            clear_num();
          end
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
  endtask

  task automatic bits_byte(input logic [7:0] c);
    int v;
    if (!is_digit(c)) begin
      bad = 1'b1;
      return;
    end
    if ((dcnt == 3'd0) && (c == ipp_pkg::CH_0)) lz = 1'b1;
    if (dcnt != 3'd7) dcnt = dcnt + 3'd1;
    v = int'(bacc) * 10 + int'(c) - int'(ipp_pkg::CH_0);
    bacc = (v > int'(ipp_pkg::BITS_SAT)) ? ipp_pkg::BITS_SAT : v[7:0];
  endtask

  // Advances the shadow parser by one character; the last one queues a result.
  task automatic parse_char(input logic [7:0] c, input logic last);
    logic          fam4;
    logic [7:0]    plen;
    logic [7:0]    maxb;
    ipp_pkg::res_t r;
    fam4 = 1'b0;
    plen = '0;
    if (!bad) begin
      if (in_bits) begin
        bits_byte(c);
      end else if ((c == ipp_pkg::CH_SLASH) && pmode) begin
        close_addr(fam4);
        in_bits = 1'b1;
        bits_v4 = fam4;
        clear_num();
      end else begin
        addr_byte(c);
      end
    end
    if (last) begin
      fam4 = 1'b0;
      if (!bad) begin
        if (in_bits) begin
          maxb = bits_v4 ? ipp_pkg::BITS_MAX_V4 : ipp_pkg::BITS_MAX_V6;
          if ((dcnt < 3'd1) || (dcnt > 3'd3) || (lz && (dcnt > 3'd1)) ||
              (bacc > maxb)) begin
            bad = 1'b1;
          end
          fam4 = bits_v4;
          plen = bacc;
        end else if (pmode) begin
          bad = 1'b1;
        end else begin
          close_addr(fam4);
        end
      end
      r = '0;
      if (!bad) begin
        r.valid_res  = 1'b1;
        r.is_v4      = fam4;
        r.prefix_len = plen;
        for (int k = 0; k < 8; k++) begin
          r.addr_hi = {r.addr_hi[55:0], ab[k]};
          r.addr_lo = {r.addr_lo[55:0], ab[k + 8]};
        end
      end
      parsed_addr_q.push_back(r);
      clear_all();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ipp_pkg::res_t got;
    ipp_pkg::res_t want;
    if (!rst_ni) begin
      pmode = 1'b0;
      clear_all();
      parsed_addr_q.delete();
      fail_o    = 0;
      pending_o = 0;
      reported  = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got = '{valid_res: res_mon.valid_res, is_v4: res_mon.is_v4, addr_hi: res_mon.addr_hi,
                addr_lo: res_mon.addr_lo, prefix_len: res_mon.prefix_len};
        if (parsed_addr_q.size() == 0) begin
          fail_o++;
          if (reported < 10) begin
            $display("unexpected result: valid=%0d v4=%0d hi=%h lo=%h plen=%0d",
                     got.valid_res, got.is_v4, got.addr_hi, got.addr_lo, got.prefix_len);
          end
          reported++;
        end else begin
          want = parsed_addr_q.pop_front();
          if ((got.valid_res !== want.valid_res) || (got.is_v4 !== want.is_v4) ||
              (got.addr_hi !== want.addr_hi) || (got.addr_lo !== want.addr_lo) ||
              (got.prefix_len !== want.prefix_len)) begin
            fail_o++;
            if (reported < 10) begin
              $display("mismatch: exp valid=%0d v4=%0d hi=%h lo=%h plen=%0d",
                       want.valid_res, want.is_v4, want.addr_hi, want.addr_lo, want.prefix_len);
              $display("          got valid=%0d v4=%0d hi=%h lo=%h plen=%0d",
                       got.valid_res, got.is_v4, got.addr_hi, got.addr_lo, got.prefix_len);
            end
            reported++;
          end
        end
      end
      if (char_mon.valid && char_mon.ready) parse_char(char_mon.char_code, char_mon.last_char);
      // Mode writes only happen with no text in flight, so the order here is safe.
      if (cfg_we_i) pmode = cfg_wdata_i;
      pending_o = parsed_addr_q.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASE_CHARS     = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;

  ipp_char_if ch ();
  ipp_res_if  rs ();

  ip_address_text_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .char_i      (ch),
    .res_o       (rs)
  );

  ipp_result_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .char_mon    (ch),
    .res_mon     (rs),
    .fail_o      (fail_count),
    .pending_o   (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((ch.valid && ch.ready) || (rs.valid && rs.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result side: always ready, coin-flip ready, or occasional long stalls.
  initial begin
    int stall_left;
    int rx_mode;
    stall_left = 0;
    rx_mode    = 0;
    rs.ready   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rs.ready = 1'b0;
        stall_left--;
      end else begin
        case (rx_mode)
          0: rs.ready = 1'b1;
          1: rs.ready = 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 9) == 0) begin
              stall_left = $urandom_range(1, 25);
              rs.ready   = 1'b0;
            end else begin
              rs.ready = 1'b1;
            end
          end
        endcase
        if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 2);
      end
    end
  end

  logic [7:0] text_buf [$];
  int         burst_left = 0;
  bit         tx_steady = 1'b0;

  string bare_cases [$] = '{
    "0.0.0.0", "255.255.255.255", "256.1.1.1", "01.1.1.1", "1.2.3", "1.2.3.4.5",
    "a.1.1.1", "::", "::1", "1::", "1:2:3:4:5:6:7:8", "1:2:3:4:5:6:7:8:9", "12345::",
    "::ffff:1.2.3.4", "1::2::3", "fe80::1%0", "1:2", "/", "ABCD:ef01::"
  };
  string prefix_cases [$] = '{
    "10.0.0.0/8", "0.0.0.0/32", "1.2.3.4/33", "::/128", "::/129", "1.2.3.4/08",
    "1.2.3.4", "1.2.3.4/1/2", "::/", "::/99999"
  };

  // Drives one character request; unless tx_steady is set, gaps come between bursts of random length.
  task automatic send_char(input logic [7:0] c, input logic last);
    if (burst_left == 0) begin
      if (!tx_steady) begin
        ch.valid = 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    ch.valid     = 1'b1;
    ch.char_code = c;
    ch.last_char = last;
    do @(posedge clk_i); while (!ch.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic settle();
    ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic put_dec(input int v);
    if ($urandom_range(0, 19) == 0) text_buf.push_back(ipp_pkg::CH_0);
    put_str($sformatf("%0d", v));
  endtask

  task automatic put_v4();
    for (int i = 0; i < 4; i++) begin
      if (i != 0) text_buf.push_back(ipp_pkg::CH_DOT);
      put_dec(($urandom_range(0, 14) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255));
    end
  endtask

  task automatic put_v6();
    int   ng;
    int   gs;
    int   gl;
    int   k;
    int   g;
    int   ndig;
    int   nib;
    bit   tail;
    bit   gap;
    bit   sep;
    bit   upper;
    tail = ($urandom_range(0, 4) == 0);
    ng   = tail ? 6 : 8;
    if ($urandom_range(0, 9) == 0) ng = ng + $urandom_range(0, 2) - 1;
    gap = ($urandom_range(0, 9) < 7);
    gs  = $urandom_range(0, ng - 1);
    gl  = $urandom_range(1, ng - gs);
    k   = 0;
    sep = 1'b0;
    while (k < ng) begin
      if (gap && (k == gs)) begin
        text_buf.push_back(ipp_pkg::CH_COLON);
        text_buf.push_back(ipp_pkg::CH_COLON);
        k   = k + gl;
        sep = 1'b0;
      end else begin
        if (sep) text_buf.push_back(ipp_pkg::CH_COLON);
        case ($urandom_range(0, 3))
          0: g = 0;
          1: g = $urandom_range(0, 255);
          default: g = $urandom_range(0, 65535);
        endcase
        ndig  = (g < 16) ? 1 : (g < 256) ? 2 : (g < 4096) ? 3 : 4;
        ndig  = ($urandom_range(0, 29) == 0) ? 5 : $urandom_range(ndig, 4);
        upper = 1'($urandom_range(0, 1));
        for (int i = ndig - 1; i >= 0; i--) begin
          nib = (g >> (4 * i)) & 15;
          if (nib < 10) begin
            text_buf.push_back(8'(int'(ipp_pkg::CH_0) + nib));
          end else begin
            text_buf.push_back(8'(int'(upper ? ipp_pkg::CH_UP_A : ipp_pkg::CH_LO_A) + nib - 10));
          end
        end
        sep = 1'b1;
        k++;
      end
    end
    if (tail) begin
      if (sep) text_buf.push_back(ipp_pkg::CH_COLON);
      put_v4();
    end
  endtask

  // Mostly well-formed addresses with random content, plus broken texts and noise.
  task automatic build_text(input logic pm);
    string charset;
    int    kind;
    int    pos;
    charset = "0123456789abcdefABCDEF:./%gx ";
    text_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1) == 0) begin
          text_buf.push_back(charset[$urandom_range(0, charset.len() - 1)]);
        end else begin
          text_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
    end else begin
      if (kind < 50) put_v4();
      else put_v6();
      if (pm ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0)) begin
        text_buf.push_back(ipp_pkg::CH_SLASH);
        put_dec(($urandom_range(0, 19) == 0) ? $urandom_range(200, 99999) : $urandom_range(0, 140));
      end
      if ($urandom_range(0, 4) == 0) begin
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: text_buf[pos] = 8'($urandom_range(0, 255));
          1: text_buf.delete(pos);
          2: text_buf.insert(pos, text_buf[pos]);
          default: text_buf.insert(pos, charset[$urandom_range(22, 25)]);
        endcase
      end
    end
    if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [5:0] mode_plan;
    int         phase_chars;
    mode_plan    = 6'b010110;
    ch.valid     = 1'b0;
    ch.char_code = '0;
    ch.last_char = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_mode(1'b0);
    foreach (bare_cases[i]) begin
      text_buf.delete();
      put_str(bare_cases[i]);
      send_text();
    end
    settle();
    write_mode(1'b1);
    foreach (prefix_cases[i]) begin
      text_buf.delete();
      put_str(prefix_cases[i]);
      send_text();
    end

    for (int p = 0; p < 6; p++) begin
      // The sender holds off here until every queued result has come back.
      settle();
      write_mode(mode_plan[p]);
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        tx_steady = ($urandom_range(0, 6) == 0);
        build_text(mode_plan[p]);
        send_text();
        phase_chars += text_buf.size();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ipp_pkg.sv
design/ipp_char_if.sv
design/ipp_res_if.sv
design/ipp_scan.sv
design/ipp_finish.sv
design/ip_address_text_parser.sv
tb/sv/ipp_result_checker.sv
tb/sv/testbench.sv
